// ===== hdl/fmpm_pkg.sv =====
`default_nettype none
package fmpm_pkg;

    localparam int PHASE_BITS_DEF  = 32;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int GAIN_W  = 31;
    localparam int AMP_W   = 15;
    localparam int ANGLE_W = 32;
    localparam int OUT_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DEV_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MUTE      = 2'd2;

    localparam logic [GAIN_W-1:0] DEV_GAIN_RST  = 31'd559240533;
    localparam logic [AMP_W-1:0]  AMPLITUDE_RST = 15'd29204;

    localparam logic [29:0] AMP_COMP   = 30'd652032874;
    localparam int          AMP_SHIFT  = 22;
    localparam int          AMP_X_W    = 23;
    localparam int          XY_W       = 26;
    localparam int          ROT_STEPS  = 20;
    localparam int          ITER_W     = 5;
    localparam int          QUEUE_DEPTH = 4;

    typedef struct packed {
        logic                 mute;
        logic [ANGLE_W-1:0]   angle;
    } t_fe_item;

    function automatic logic [ANGLE_W-1:0] atan_turns(input logic [ITER_W-1:0] idx);
        logic [ANGLE_W-1:0] v;
        unique case (idx)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051E;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2F;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2FA;
            5'd15:   v = 32'h0000_517D;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A30;
            5'd19:   v = 32'h0000_0518;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/fm_phase_modulator_core.sv =====
// Unmuted items pass one at a time through the shared 20-step CORDIC rotator;
// muted items skip it and load zeros straight into the output register.
// The input side runs ahead into a 4-entry queue, so accepts continue
// while the rotator is busy.
// Reset (synchronous, active low): phase zero, queue and output empty,
// registers at gain 559240533, amplitude 29204, mute off.
`default_nettype none
module fm_phase_modulator_core #(
    parameter int PHASE_BITS  = fmpm_pkg::PHASE_BITS_DEF,
    parameter int SAMPLE_BITS = fmpm_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    // [SAMPLE_BITS-1:0] audio_sample, zero fill to a whole byte
    input  wire logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    output logic                                      o_m_axis_tvalid,
    input  wire logic                                 i_m_axis_tready,
    // [15:0] out_i, [31:16] out_q
    output logic [2 * fmpm_pkg::OUT_W - 1:0]          o_m_axis_tdata,
    input  wire logic                                 i_cfg_we,
    input  wire logic [fmpm_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  wire logic [fmpm_pkg::GAIN_W-1:0]          i_cfg_wdata
);

    logic [fmpm_pkg::GAIN_W-1:0] r_dev_gain;
    logic [fmpm_pkg::AMP_W-1:0]  r_amplitude;
    logic                        r_mute;

    logic               w_push;
    logic               w_full;
    logic               w_pop;
    logic               w_empty;
    fmpm_pkg::t_fe_item w_push_item;
    fmpm_pkg::t_fe_item w_head_item;
    logic signed [fmpm_pkg::OUT_W-1:0] w_out_i;
    logic signed [fmpm_pkg::OUT_W-1:0] w_out_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_gain  <= fmpm_pkg::DEV_GAIN_RST;
            r_amplitude <= fmpm_pkg::AMPLITUDE_RST;
            r_mute      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                fmpm_pkg::REG_DEV_GAIN:  r_dev_gain  <= i_cfg_wdata;
                fmpm_pkg::REG_AMPLITUDE: r_amplitude <= i_cfg_wdata[fmpm_pkg::AMP_W-1:0];
                fmpm_pkg::REG_MUTE:      r_mute      <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    fmpm_front #(
        .PHASE_BITS  (PHASE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_sample ($signed(i_s_axis_tdata[SAMPLE_BITS-1:0])),
        .i_gain   (r_dev_gain),
        .i_mute   (r_mute),
        .o_push   (w_push),
        .o_item   (w_push_item),
        .i_full   (w_full)
    );

    fmpm_queue #(
        .DEPTH (fmpm_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_item  (w_head_item),
        .o_empty (w_empty)
    );

    fmpm_rotator u_rotator (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_amplitude (r_amplitude),
        .i_empty     (w_empty),
        .i_item      (w_head_item),
        .o_pop       (w_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_i         (w_out_i),
        .o_q         (w_out_q)
    );

    assign o_m_axis_tdata = {w_out_q, w_out_i};

endmodule
`default_nettype wire

// ===== hdl/fmpm_front.sv =====
`default_nettype none
module fmpm_front #(
    parameter int PHASE_BITS  = fmpm_pkg::PHASE_BITS_DEF,
    parameter int SAMPLE_BITS = fmpm_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]     i_sample,
    input  wire logic [fmpm_pkg::GAIN_W-1:0]       i_gain,
    input  wire logic                              i_mute,
    output logic                                   o_push,
    output fmpm_pkg::t_fe_item                     o_item,
    input  wire logic                              i_full
);

    localparam int PROD_W = fmpm_pkg::GAIN_W + 1 + SAMPLE_BITS;
    localparam int STEP_W = PROD_W - SAMPLE_BITS + 1;
    localparam int EXT_W  = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;

    logic                      r_vld;
    logic                      r_mute;
    logic signed [PROD_W-1:0]  r_prod;
    logic [PHASE_BITS-1:0]     r_phase;
    logic signed [STEP_W-1:0]  w_step;
    logic signed [EXT_W-1:0]   w_step_ext;
    logic [PHASE_BITS-1:0]     n_phase;
    logic [fmpm_pkg::ANGLE_W-1:0] w_angle;

    assign o_ready = !r_vld || !i_full;
    assign o_push  = r_vld && !i_full;

    assign w_step     = $signed(r_prod[PROD_W-1:SAMPLE_BITS-1]);
    assign w_step_ext = EXT_W'(w_step);
    assign n_phase    = r_phase + w_step_ext[PHASE_BITS-1:0];

    generate
        if (PHASE_BITS >= fmpm_pkg::ANGLE_W) begin : g_top
            assign w_angle = n_phase[PHASE_BITS-1 -: fmpm_pkg::ANGLE_W];
        end else begin : g_pad
            assign w_angle = {n_phase, {(fmpm_pkg::ANGLE_W - PHASE_BITS){1'b0}}};
        end
    endgenerate

    assign o_item.mute  = r_mute;
    assign o_item.angle = w_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_phase <= '0;
        end else begin
            if (o_push && !r_mute) begin
                r_phase <= n_phase;
            end
            if (i_valid && o_ready) begin
                r_vld <= 1'b1;
            end else if (o_push) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_prod <= $signed({1'b0, i_gain}) * i_sample;
            r_mute <= i_mute;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/fmpm_queue.sv =====
`default_nettype none
module fmpm_queue #(
    parameter int DEPTH = fmpm_pkg::QUEUE_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire fmpm_pkg::t_fe_item i_item,
    output logic                    o_full,
    input  wire logic               i_pop,
    output fmpm_pkg::t_fe_item      o_item,
    output logic                    o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fmpm_pkg::t_fe_item r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/fmpm_rotator.sv =====
`default_nettype none
module fmpm_rotator (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [fmpm_pkg::AMP_W-1:0]   i_amplitude,
    input  wire logic                         i_empty,
    input  wire fmpm_pkg::t_fe_item           i_item,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic signed [fmpm_pkg::OUT_W-1:0] o_i,
    output logic signed [fmpm_pkg::OUT_W-1:0] o_q
);

    localparam int XY_W  = fmpm_pkg::XY_W;
    localparam int Z_W   = fmpm_pkg::ANGLE_W;
    localparam int AX_W  = fmpm_pkg::AMP_X_W;
    localparam int AP_W  = fmpm_pkg::AMP_W + 30;
    localparam int RND_W = XY_W + 1;
    localparam int SH_W  = RND_W - 8;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic signed [Z_W:0] QUARTER = 33'sh0_4000_0000;
    localparam logic signed [Z_W:0] HALF    = 33'sh0_8000_0000;
    localparam logic [fmpm_pkg::ITER_W-1:0] LAST_ITER =
        fmpm_pkg::ITER_W'(fmpm_pkg::ROT_STEPS - 1);

    logic [1:0]                      r_state;
    logic [fmpm_pkg::ITER_W-1:0]     r_iter;
    logic [AX_W-1:0]                 r_amp_x;
    logic signed [XY_W-1:0]          r_x;
    logic signed [XY_W-1:0]          r_y;
    logic signed [Z_W-1:0]           r_z;
    logic                            r_out_vld;
    logic signed [fmpm_pkg::OUT_W-1:0] r_out_i;
    logic signed [fmpm_pkg::OUT_W-1:0] r_out_q;

    logic [AP_W-1:0]         w_amp_prod;
    logic                    w_out_free;
    logic                    w_out_load;
    logic signed [Z_W:0]     w_z0;
    logic signed [Z_W:0]     w_zf;
    logic                    w_neg;
    logic signed [XY_W-1:0]  w_x0;
    logic signed [XY_W-1:0]  w_dx;
    logic signed [XY_W-1:0]  w_dy;
    logic signed [Z_W-1:0]   w_atan;
    logic signed [fmpm_pkg::OUT_W-1:0] w_ri;
    logic signed [fmpm_pkg::OUT_W-1:0] w_rq;

    function automatic logic signed [fmpm_pkg::OUT_W-1:0] round_sat(
        input logic signed [XY_W-1:0] v
    );
        logic signed [RND_W-1:0] s;
        logic signed [SH_W-1:0]  r;
        logic signed [fmpm_pkg::OUT_W-1:0] o;
        s = RND_W'(v) + RND_W'(128);
        r = SH_W'(s >>> 8);
        if (r > SH_W'(32767)) begin
            o = 16'sh7FFF;
        end else if (r < -SH_W'(32768)) begin
            o = -16'sh8000;
        end else begin
            o = fmpm_pkg::OUT_W'(r);
        end
        return o;
    endfunction

    assign w_amp_prod = AP_W'(i_amplitude) * AP_W'(fmpm_pkg::AMP_COMP);
    assign w_out_free = !r_out_vld || i_ready;

    assign w_z0 = (Z_W + 1)'($signed(i_item.angle));
    always_comb begin
        w_neg = 1'b0;
        w_zf  = w_z0;
        if (w_z0 > QUARTER) begin
            w_zf  = w_z0 - HALF;
            w_neg = 1'b1;
        end else if (w_z0 < -QUARTER) begin
            w_zf  = w_z0 + HALF;
            w_neg = 1'b1;
        end
    end
    assign w_x0 = w_neg ? -$signed(XY_W'(r_amp_x)) : $signed(XY_W'(r_amp_x));

    assign w_dx   = r_y >>> r_iter;
    assign w_dy   = r_x >>> r_iter;
    assign w_atan = $signed(fmpm_pkg::atan_turns(r_iter));
    assign w_ri   = round_sat(r_x);
    assign w_rq   = round_sat(r_y);

    assign o_pop   = (r_state == ST_IDLE) && !i_empty && (!i_item.mute || w_out_free);
    assign o_valid = r_out_vld;
    assign o_i     = r_out_i;
    assign o_q     = r_out_q;

    assign w_out_load = (o_pop && i_item.mute) || ((r_state == ST_DONE) && w_out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop && !i_item.mute) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (r_iter == LAST_ITER) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_amp_x <= AX_W'(w_amp_prod >> fmpm_pkg::AMP_SHIFT);
        if (r_state == ST_IDLE) begin
            r_iter <= '0;
            r_x    <= w_x0;
            r_y    <= '0;
            r_z    <= Z_W'(w_zf);
            if (o_pop && i_item.mute) begin
                r_out_i <= '0;
                r_out_q <= '0;
            end
        end else if (r_state == ST_RUN) begin
            r_iter <= r_iter + 1'b1;
            if (!r_z[Z_W-1]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_atan;
            end
        end else if (w_out_free) begin
            r_out_i <= w_ri;
            r_out_q <= w_rq;
        end
    end

endmodule
`default_nettype wire

// ===== dv/fm_phase_modulator_core_test.sv =====
module fm_phase_modulator_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [fmpm_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int     CYCLE_LIMIT   = 300000;
    localparam int     RAND_SETTINGS = 10;
    localparam int     RAND_PER_SET  = 125;
    localparam longint QUARTER_TURN  = 64'sh4000_0000;
    localparam longint HALF_TURN     = 64'sh8000_0000;
    localparam longint ATAN_TURNS [20] = '{
        64'h2000_0000, 64'h12E4_051E, 64'h09FB_385B, 64'h0511_11D4, 64'h028B_0D43,
        64'h0145_D7E1, 64'h00A2_F61E, 64'h0051_7C55, 64'h0028_BE53, 64'h0014_5F2F,
        64'h000A_2F98, 64'h0005_17CC, 64'h0002_8BE6, 64'h0001_45F3, 64'h0000_A2FA,
        64'h0000_517D, 64'h0000_28BE, 64'h0000_145F, 64'h0000_0A30, 64'h0000_0518
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [15:0]          i_s_axis_tdata = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [31:0]          o_m_axis_tdata;
    logic                 i_cfg_we = 1'b0;
    logic [fmpm_pkg::CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [fmpm_pkg::GAIN_W-1:0]    i_cfg_wdata = '0;

    logic [fmpm_pkg::GAIN_W-1:0] cfg_gain = fmpm_pkg::DEV_GAIN_RST;
    logic [fmpm_pkg::AMP_W-1:0]  cfg_amp = fmpm_pkg::AMPLITUDE_RST;
    logic              cfg_mute = 1'b0;
    logic [31:0]       iq_phase = '0;

    logic [15:0] audio_pending [$];
    logic [31:0] iq_expected [$];
    logic [31:0] iq_want;

    logic src_idle_en = 1'b1;
    logic sink_idle_en = 1'b1;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   cycle_count = 0;
    int   n_sent = 0;
    int   n_muted = 0;
    int   n_checked = 0;
    int   n_mismatch = 0;
    int   n_settings = 1;

    fm_phase_modulator_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [15:0] round_sat16(input longint v);
        longint r;
        r = (v + 128) >>> 8;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    // advance the phase accumulator and rotate (zeros, phase held, when muted); returns {out_q, out_i}
    function automatic logic [31:0] modulate(input logic signed [15:0] sample);
        longint step, ang, x, y, dx, dy;
        if (cfg_mute) return '0;
        step = (longint'(cfg_gain) * longint'(sample)) >>> 15;
        iq_phase = iq_phase + step[31:0];
        ang = longint'($signed(iq_phase));
        x = (longint'(cfg_amp) * 64'sd652032874) >>> 22;
        y = 0;
        if (ang > QUARTER_TURN) begin
            ang -= HALF_TURN;
            x = -x;
        end else if (ang < -QUARTER_TURN) begin
            ang += HALF_TURN;
            x = -x;
        end
        for (int k = 0; k < 20; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (ang >= 0) begin
                x -= dx;
                y += dy;
                ang -= ATAN_TURNS[k];
            end else begin
                x += dx;
                y -= dy;
                ang += ATAN_TURNS[k];
            end
        end
        return {round_sat16(y), round_sat16(x)};
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                if (cfg_mute) n_muted++;
                iq_expected.push_back(modulate(i_s_axis_tdata));
                n_sent++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (audio_pending.size() != 0 &&
                    !(src_idle_en && $urandom_range(0, 99) < 14)) begin
                    i_s_axis_tdata <= audio_pending.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (iq_expected.size() == 0) begin
                    if (n_mismatch < 10) $display("unexpected iq transfer %h", o_m_axis_tdata);
                    n_mismatch++;
                end else begin
                    iq_want = iq_expected.pop_front();
                    if (o_m_axis_tdata[15:0] !== iq_want[15:0] ||
                        o_m_axis_tdata[31:16] !== iq_want[31:16]) begin
                        if (n_mismatch < 10)
                            $display("iq #%0d: i exp %0d got %0d, q exp %0d got %0d",
                                     n_checked, $signed(iq_want[15:0]),
                                     $signed(o_m_axis_tdata[15:0]),
                                     $signed(iq_want[31:16]),
                                     $signed(o_m_axis_tdata[31:16]));
                        n_mismatch++;
                    end
                end
                n_checked++;
            end
            // hold off long enough to back up the input queue
            if (n_checked == 300 && !hold_done) begin
                hold_left = 500;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= !(sink_idle_en && $urandom_range(0, 99) < 14);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d iq transfers pending",
                     cycle_count, iq_expected.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic cfg_write(input logic [fmpm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fmpm_pkg::GAIN_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        case (idx)
            fmpm_pkg::REG_DEV_GAIN:  cfg_gain = val;
            fmpm_pkg::REG_AMPLITUDE: cfg_amp = val[fmpm_pkg::AMP_W-1:0];
            fmpm_pkg::REG_MUTE:      cfg_mute = val[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (audio_pending.size() != 0 || i_s_axis_tvalid || iq_expected.size() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    initial begin
        logic [fmpm_pkg::GAIN_W-1:0] gain_val;
        logic [fmpm_pkg::AMP_W-1:0]  amp_val;
        logic [15:0]       sample;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, phase past a quarter turn and back
        audio_pending.push_back(16'h0000);
        audio_pending.push_back(16'h7FFF);
        audio_pending.push_back(16'h7FFF);
        audio_pending.push_back(16'h7FFF);
        audio_pending.push_back(16'h8000);
        audio_pending.push_back(16'h8000);
        audio_pending.push_back(16'h0001);
        audio_pending.push_back(16'hFFFF);
        drain();

        // largest gain and amplitude; spare index must change nothing
        cfg_write(fmpm_pkg::REG_DEV_GAIN, 31'h7FFF_FFFF);
        cfg_write(fmpm_pkg::REG_AMPLITUDE, 31'h7FFF_FFFF);
        cfg_write(REG_SPARE, 31'h7FFF_FFFF);
        n_settings++;
        audio_pending.push_back(16'h7FFF);
        audio_pending.push_back(16'h8000);
        audio_pending.push_back(16'h8000);
        audio_pending.push_back(16'h4000);
        audio_pending.push_back(16'hC000);
        audio_pending.push_back(16'h5555);
        drain();

        // mute with junk upper bits: zeros out, phase frozen
        cfg_write(fmpm_pkg::REG_MUTE, 31'h7FFF_FFFF);
        n_settings++;
        audio_pending.push_back(16'h7FFF);
        audio_pending.push_back(16'h8000);
        audio_pending.push_back(16'h1234);
        drain();

        cfg_write(fmpm_pkg::REG_MUTE, 31'h0000_0002);
        cfg_write(fmpm_pkg::REG_AMPLITUDE, 31'h7FFF_8000);
        n_settings++;
        audio_pending.push_back(16'h0000);
        audio_pending.push_back(16'h7FFF);
        drain();

        cfg_write(fmpm_pkg::REG_DEV_GAIN, 31'h0);
        cfg_write(fmpm_pkg::REG_AMPLITUDE, 31'h1);
        n_settings++;
        audio_pending.push_back(16'h8000);
        audio_pending.push_back(16'h3C3C);
        drain();

        for (int s = 0; s < RAND_SETTINGS; s++) begin
            src_idle_en = (s != 0);
            sink_idle_en = (s != 0);
            case ($urandom_range(0, 4))
                0:       gain_val = '0;
                1:       gain_val = 31'h7FFF_FFFF;
                2:       gain_val = 31'($urandom_range(0, 1 << 20));
                default: gain_val = 31'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       amp_val = '0;
                1:       amp_val = 15'h7FFF;
                default: amp_val = 15'($urandom_range(0, 32767));
            endcase
            cfg_write(fmpm_pkg::REG_DEV_GAIN, gain_val);
            cfg_write(fmpm_pkg::REG_AMPLITUDE, {16'($urandom), amp_val});
            cfg_write(fmpm_pkg::REG_MUTE, {30'($urandom), ($urandom_range(0, 4) == 0)});
            if ($urandom_range(0, 2) == 0) cfg_write(REG_SPARE, 31'($urandom));
            n_settings++;
            for (int n = 0; n < RAND_PER_SET; n++) begin
                case ($urandom_range(0, 9))
                    0: begin
                        case ($urandom_range(0, 4))
                            0:       sample = 16'h7FFF;
                            1:       sample = 16'h8000;
                            2:       sample = 16'h0001;
                            3:       sample = 16'hFFFF;
                            default: sample = 16'h0000;
                        endcase
                    end
                    1, 2:    sample = 16'($signed($urandom_range(0, 511)) - 256);
                    default: sample = 16'($urandom);
                endcase
                audio_pending.push_back(sample);
            end
            drain();
        end

        if (iq_expected.size() != 0) n_mismatch += iq_expected.size();
        $display("sent %0d audio samples (%0d muted) across %0d register settings",
                 n_sent, n_muted, n_settings);
        $display("checked %0d iq transfers, %0d mismatches", n_checked, n_mismatch);
        if (n_mismatch == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
